FILE: rtl/vct_pkg.sv
package vct_pkg;

    localparam int COMPONENT_BITS = 16;
    localparam int FIELD_W        = 16;
    localparam int SQ_W           = 2 * COMPONENT_BITS;
    localparam int P_W            = 2 * SQ_W;
    localparam int Q_W            = 16;
    localparam int QB_W           = $clog2(Q_W);
    localparam int FRAC_SHIFT     = 30;
    localparam int W              = P_W + 2 * Q_W + 2;
    localparam int IN_W           = 6 * FIELD_W;
    localparam int N_VEC          = 3;

    // one slot of the cosine search chain
    typedef struct packed {
        logic           valid;
        logic           zero;
        logic           neg;
        logic [W-1:0]   rem;
        logic [W-1:0]   qp;
        logic [W-1:0]   p;
        logic [Q_W-1:0] q;
    } vct_cell_t;

endpackage

FILE: rtl/view_cone_test_3d.sv
// view cone test: for each input beat with a facing vector and a target
// direction, gives cos(angle) = dot / (|f| |t|) in Q1.15, truncated toward
// zero, parallel vectors saturated to +32767 and zero-length vectors giving
// 0, plus in_view = cosine > cos_threshold (signed Q1.15). when not stalled,
// one beat is taken every cycle; the pipe has three front stages (products,
// sums, norm product and squared dot), a chain of 16 search cells that each
// fix one bit of the cosine, and the output register. a stall on the master
// side holds the whole pipe, so s_tready follows m_tready when the output
// register is full. cos_threshold should be written only while idle
module view_cone_test_3d (
    input  logic                          clk,
    input  logic                          rst_n,
    // facing_x, facing_y, facing_z, target_x, target_y, target_z (lsb first)
    input  logic [vct_pkg::IN_W-1:0]      s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cosine
    output logic [15:0]                   m_tdata,
    // in_view
    output logic                          m_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [15:0]                   cfg_data
);

    vct_pkg::vct_cell_t chain [vct_pkg::Q_W+1];

    logic        en;
    logic        out_valid_reg;
    logic [15:0] cos_reg, cos_next;
    logic        view_reg, view_next;
    logic [15:0] thr_reg;

    // pipe advances whenever the output register can take a beat
    assign en        = !out_valid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_valid)
        begin
            thr_reg <= cfg_data;
        end
    end

    vct_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .out_cell (chain[0])
    );

    // search chain, most significant cosine bit first
    for (genvar i = 0; i < vct_pkg::Q_W; i++)
    begin : g_cell
        vct_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .bit_idx  (vct_pkg::QB_W'(vct_pkg::Q_W - 1 - i)),
            .in_cell  (chain[i]),
            .out_cell (chain[i+1])
        );
    end

    // sign, saturation and threshold compare
    always_comb
    begin
        if (chain[vct_pkg::Q_W].zero)
            cos_next = '0;
        else if (chain[vct_pkg::Q_W].neg)
            cos_next = 16'(~chain[vct_pkg::Q_W].q + 1'b1);
        else if (chain[vct_pkg::Q_W].q[15])
            cos_next = 16'h7fff;
        else
            cos_next = chain[vct_pkg::Q_W].q;
        view_next = $signed(cos_next) > $signed(thr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= chain[vct_pkg::Q_W].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg  <= cos_next;
            view_reg <= view_next;
        end
    end

    assign m_tdata  = cos_reg;
    assign m_tuser  = view_reg;
    assign m_tvalid = out_valid_reg;

endmodule

FILE: rtl/vct_front.sv
module vct_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [vct_pkg::IN_W-1:0] in_data,
    output vct_pkg::vct_cell_t       out_cell
);

    localparam int CB = vct_pkg::COMPONENT_BITS;

    logic [CB-1:0]   fm [vct_pkg::N_VEC];
    logic [CB-1:0]   tm [vct_pkg::N_VEC];
    logic            fn [vct_pkg::N_VEC];
    logic            tn [vct_pkg::N_VEC];

    logic [2*CB-1:0] pf_reg [vct_pkg::N_VEC];
    logic [2*CB-1:0] sf_reg [vct_pkg::N_VEC];
    logic [2*CB-1:0] st_reg [vct_pkg::N_VEC];
    logic            ng_reg [vct_pkg::N_VEC];
    logic            a_valid_reg;

    logic [vct_pkg::SQ_W-1:0] pos_next, negs_next, na_next, nb_next;
    logic [vct_pkg::SQ_W-1:0] dmag_reg, na_reg, nb_reg;
    logic                     dneg_reg, b_valid_reg;

    vct_pkg::vct_cell_t       cell_next, cell_reg;
    logic [vct_pkg::P_W-1:0]  p_prod, d_sq;

    // magnitude and sign of each component
    always_comb
    begin
        for (int k = 0; k < vct_pkg::N_VEC; k++)
        begin
            fn[k] = in_data[k*vct_pkg::FIELD_W + CB - 1];
            tn[k] = in_data[(k+3)*vct_pkg::FIELD_W + CB - 1];
            fm[k] = fn[k] ? (~in_data[k*vct_pkg::FIELD_W +: CB] + 1'b1)
                          : in_data[k*vct_pkg::FIELD_W +: CB];
            tm[k] = tn[k] ? (~in_data[(k+3)*vct_pkg::FIELD_W +: CB] + 1'b1)
                          : in_data[(k+3)*vct_pkg::FIELD_W +: CB];
        end
    end

    // stage a: component products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < vct_pkg::N_VEC; k++)
            begin
                pf_reg[k] <= fm[k] * tm[k];
                sf_reg[k] <= fm[k] * fm[k];
                st_reg[k] <= tm[k] * tm[k];
                ng_reg[k] <= fn[k] ^ tn[k];
            end
        end
    end

    // stage b: sums
    always_comb
    begin
        pos_next  = '0;
        negs_next = '0;
        na_next   = '0;
        nb_next   = '0;
        for (int k = 0; k < vct_pkg::N_VEC; k++)
        begin
            if (ng_reg[k])
                negs_next = negs_next + vct_pkg::SQ_W'(pf_reg[k]);
            else
                pos_next = pos_next + vct_pkg::SQ_W'(pf_reg[k]);
            na_next = na_next + vct_pkg::SQ_W'(sf_reg[k]);
            nb_next = nb_next + vct_pkg::SQ_W'(st_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            na_reg   <= na_next;
            nb_reg   <= nb_next;
            dneg_reg <= pos_next < negs_next;
            dmag_reg <= (pos_next < negs_next) ? (negs_next - pos_next)
                                               : (pos_next - negs_next);
        end
    end

    // stage c: norm product and squared dot, seeds the search chain
    assign p_prod = na_reg * nb_reg;
    assign d_sq   = dmag_reg * dmag_reg;

    always_comb
    begin
        cell_next.valid = b_valid_reg;
        cell_next.zero  = (na_reg == '0) || (nb_reg == '0) || (dmag_reg == '0);
        cell_next.neg   = dneg_reg;
        cell_next.rem   = vct_pkg::W'(d_sq) << vct_pkg::FRAC_SHIFT;
        cell_next.qp    = '0;
        cell_next.p     = vct_pkg::W'(p_prod);
        cell_next.q     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign out_cell = cell_reg;

endmodule

FILE: rtl/vct_cell.sv
module vct_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic [vct_pkg::QB_W-1:0] bit_idx,
    input  vct_pkg::vct_cell_t       in_cell,
    output vct_pkg::vct_cell_t       out_cell
);

    logic [vct_pkg::W-1:0] trial;
    logic                  take;
    vct_pkg::vct_cell_t    cell_next, cell_reg;

    // (q + 2^b)^2 p - q^2 p = 2^(b+1) qp + 2^(2b) p
    always_comb
    begin
        trial = (in_cell.qp << ({1'b0, bit_idx} + 1'b1))
              + (in_cell.p << {bit_idx, 1'b0});
        take  = trial <= in_cell.rem;
        cell_next = in_cell;
        if (take)
        begin
            cell_next.rem = in_cell.rem - trial;
            cell_next.qp  = in_cell.qp + (in_cell.p << bit_idx);
            cell_next.q   = in_cell.q | (vct_pkg::Q_W'(1) << bit_idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign out_cell = cell_reg;

endmodule

FILE: sim/view_cone_test_3d_test.sv
`timescale 1ns / 100ps

module view_cone_test_3d_test;

    // expected cosine / in_view pair for one accepted vector beat
    typedef struct {
        logic signed [15:0] cosine;
        logic               in_view;
    } cone_result_t;

    // scoreboard: holds the threshold copy and the queue of expected cone results
    class cone_scoreboard;
        logic signed [15:0] threshold;
        cone_result_t       pending_q[$];
        int                 errors;
        int                 beats_in;
        int                 beats_out;
        int                 zero_cases;
        int                 saturated;

        function new();
            threshold = 16'sd0;
            errors    = 0;
            beats_in  = 0;
            beats_out = 0;
            zero_cases = 0;
            saturated = 0;
        endfunction

        // exact cosine: largest q with q*q*|f|^2*|t|^2 <= 2^30*dot^2
        function cone_result_t cone_cosine(logic [95:0] vec);
            cone_result_t res;
            int signed          fc[3];
            int signed          tc[3];
            longint signed      dot;
            longint unsigned    fnorm;
            longint unsigned    tnorm;
            longint unsigned    dmag;
            logic [127:0]       wide;
            logic [127:0]       norm_prod;
            logic [127:0]       dot_sq;
            logic [127:0]       lhs;
            int                 lo;
            int                 hi;
            int                 mid;
            dot = 0;
            fnorm = 0;
            tnorm = 0;
            for (int k = 0; k < 3; k++)
            begin
                fc[k] = $signed(vec[16*k +: 16]);
                tc[k] = $signed(vec[48 + 16*k +: 16]);
                dot   = dot + longint'(fc[k]) * longint'(tc[k]);
                fnorm = fnorm + longint'(fc[k]) * longint'(fc[k]);
                tnorm = tnorm + longint'(tc[k]) * longint'(tc[k]);
            end
            dmag = (dot < 0) ? longint'(-dot) : longint'(dot);
            res.cosine = 16'sd0;
            if (fnorm == 0 || tnorm == 0)
                zero_cases++;
            if (fnorm != 0 && tnorm != 0 && dmag != 0)
            begin
                wide      = 128'(fnorm);
                norm_prod = wide * 128'(tnorm);
                wide      = 128'(dmag);
                dot_sq    = (wide * wide) << 30;
                lo = 0;
                hi = 32768;
                while (lo < hi)
                begin
                    mid = (lo + hi + 1) / 2;
                    lhs = 128'(longint'(mid) * longint'(mid)) * norm_prod;
                    if (lhs <= dot_sq)
                        lo = mid;
                    else
                        hi = mid - 1;
                end
                if (dot < 0)
                    res.cosine = 16'(-lo);
                else if (lo > 32767)
                begin
                    res.cosine = 16'sd32767;
                    saturated++;
                end
                else
                    res.cosine = 16'(lo);
            end
            res.in_view = (res.cosine > threshold);
            return res;
        endfunction

        function void note_vectors(logic [95:0] vec);
            pending_q.push_back(cone_cosine(vec));
            beats_in++;
        endfunction

        function void check_result(logic [15:0] cosine, logic in_view);
            cone_result_t exp;
            beats_out++;
            if (pending_q.size() == 0)
            begin
                $error("unexpected result beat: cosine %0d in_view %0d",
                       $signed(cosine), in_view);
                errors++;
                return;
            end
            exp = pending_q.pop_front();
            if (cosine !== exp.cosine)
            begin
                $error("cosine: expected %0d, actual %0d", exp.cosine, $signed(cosine));
                errors++;
            end
            if (in_view !== exp.in_view)
            begin
                $error("in_view: expected %0d, actual %0d", exp.in_view, in_view);
                errors++;
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_BEATS    = 260;

    logic        clk;
    logic        rst_n;
    logic [95:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    cone_scoreboard sb;
    bit  no_gaps;       // long stretch with neither side idling
    bit  hold_request;  // receiver backs off for a long stretch
    int  idle_cycles;   // cycles since anything was accepted

    view_cone_test_3d dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // receiver: random backpressure, a long hold-off on request
    initial
    begin
        int hold_left;
        m_tready  = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request && hold_left == 0)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else if (no_gaps)
                m_tready = 1'b1;
            else
                m_tready = ($urandom_range(99) >= 31);
        end
    end

    // result check on the rising edge, plus the stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired after %0d stalled cycles", idle_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // one vector beat; random gaps before it unless the no-gap stretch is on
    task automatic send_vectors(logic [95:0] vec);
        @(negedge clk);
        while (!no_gaps && $urandom_range(99) < 31)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = vec;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_vectors(vec);
    endtask

    task automatic send_components(int fx, int fy, int fz, int tx, int ty, int tz);
        send_vectors({16'(tz), 16'(ty), 16'(tx), 16'(fz), 16'(fy), 16'(fx)});
    endtask

    // wait until the pipe has drained, then write the threshold
    task automatic set_threshold(logic [15:0] value);
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.threshold = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // random vector pair, mostly structured so cosines spread over the range
    function automatic logic [95:0] random_vectors();
        logic [95:0] vec;
        int          kind;
        int          scale;
        int          comp;
        kind = $urandom_range(9);
        vec  = {$urandom, $urandom, $urandom};
        if (kind < 3)
        begin
            // small components
            for (int k = 0; k < 6; k++)
            begin
                comp = $signed($urandom_range(14)) - 7;
                vec[16*k +: 16] = 16'(comp);
            end
        end
        else if (kind < 6)
        begin
            // target close to a multiple of facing: cosine near +1 or -1
            scale = ($urandom_range(1)) ? 1 : -1;
            for (int k = 0; k < 3; k++)
            begin
                comp = $signed(vec[16*k +: 16]) / 4;
                vec[16*k +: 16] = 16'(comp);
                comp = scale * comp + $signed($urandom_range(6)) - 3;
                vec[48 + 16*k +: 16] = 16'(comp);
            end
        end
        else if (kind == 6)
        begin
            // one vector zero
            if ($urandom_range(1))
                vec[47:0] = '0;
            else
                vec[95:48] = '0;
        end
        return vec;
    endfunction

    initial
    begin
        logic [15:0] thresholds[5];
        sb           = new();
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        no_gaps      = 1'b0;
        hold_request = 1'b0;
        idle_cycles  = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset threshold of zero
        send_components(0, 0, 0, 0, 0, 0);
        send_components(0, 0, 0, 5, -3, 2);
        send_components(7, 1, -2, 0, 0, 0);
        send_components(3, 4, 5, 3, 4, 5);                  // parallel, saturates
        send_components(3, 4, 5, -3, -4, -5);               // antiparallel
        send_components(1, 0, 0, 0, 1, 0);                  // orthogonal
        send_components(32767, 32767, 32767, 32767, 32767, 32767);
        send_components(-32768, -32768, -32768, -32768, -32768, -32768);
        send_components(-32768, -32768, -32768, 32767, 32767, 32767);
        send_components(-32768, 0, 0, 32767, 0, 0);
        send_components(32767, -32768, 1, -1, 32767, -32768);
        send_components(1, 1, 0, 1, 0, 0);
        send_components(1, 2, 3, 4, 5, 6);
        send_components(1, 0, 0, 1, 1, 0);
        set_threshold(16'h8000);                            // most negative
        send_components(0, 0, 0, 0, 0, 0);
        send_components(3, 4, 5, -3, -4, -5);
        send_components(1, 0, 0, -1, 1, 0);
        set_threshold(16'h7fff);                            // most positive
        send_components(3, 4, 5, 3, 4, 5);
        send_components(2, 0, 0, 2, 0, 0);
        set_threshold(16'h5a82);                            // near cos 45 degrees
        send_components(1, 0, 0, 1, 1, 0);
        send_components(1, 0, 0, 100, 99, 0);
        send_components(1, 0, 0, 99, 100, 0);

        // random phases across thresholds, one with no gaps and one with a hold-off
        thresholds[0] = 16'h0000;
        thresholds[1] = 16'h8000;
        thresholds[2] = 16'h7fff;
        thresholds[3] = 16'($urandom);
        thresholds[4] = 16'h6000;
        for (int ph = 0; ph < 5; ph++)
        begin
            set_threshold(thresholds[ph]);
            no_gaps = (ph == 2);
            for (int i = 0; i < PHASE_BEATS; i++)
            begin
                if (ph == 3 && i == 40)
                    hold_request = 1'b1;
                send_vectors(random_vectors());
            end
            no_gaps = 1'b0;
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d vector beats over 8 threshold settings", sb.beats_in);
        $display("%0d with a zero vector, %0d saturated at +1, %0d results checked",
                 sb.zero_cases, sb.saturated, sb.beats_out);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
